// ===== sv/abkf_pkg.sv =====
`default_nettype none
package abkf_pkg;

    localparam int CHANNELS = 3;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int CFG_W    = 31;
    localparam int MOP_W    = 34;
    localparam int MRES_W   = 44;
    localparam int SUM_W    = 48;
    localparam int NUM_W    = 56;
    localparam int DEN_W    = 32;

    localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;

    localparam logic [1:0] REG_Q_ANGLE = 2'd0;
    localparam logic [1:0] REG_Q_BIAS  = 2'd1;
    localparam logic [1:0] REG_R_NOISE = 2'd2;
    localparam logic [1:0] REG_DT      = 2'd3;

    localparam logic [CFG_W-1:0] RST_Q_ANGLE = 31'd16777;
    localparam logic [CFG_W-1:0] RST_Q_BIAS  = 31'd50332;
    localparam logic [CFG_W-1:0] RST_R_NOISE = 31'd8388608;
    localparam logic [CFG_W-1:0] RST_DT      = 31'd838861;

    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] r;
        if (v > SUM_W'(32'sh7fffffff)) r = 32'sh7fffffff;
        else if (v < -SUM_W'(64'sh80000000)) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/angle_bias_kalman_filter_core.sv =====
`default_nettype none
// Channel   Dir  Handshake                     Payload
// in        in   i_in_valid / o_in_stall       i_channel, i_observed_angle, i_gyro_rate
// out       out  o_out_valid / i_out_stall     o_channel_out, o_angle_out
// cfg       in   psel penable pwrite pready    paddr, pwdata, prdata
//
// Each accepted word makes nine passes through the shared registered multiplier and
// two 56-bit restoring divisions, each quotient picked up as its division ends.
// With a non-positive innovation variance both divisions drop; a channel out of range
// goes straight to the done state and returns a zero angle.
// The input stalls while a word is in work; a stalled result holds the sequencer in its
// last state, and the next word may enter once the result is loaded.
// Reset (synchronous, active low) sets the registers and all channel state.
module angle_bias_kalman_filter_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_channel,
    input  wire logic signed [31:0] i_observed_angle,
    input  wire logic signed [31:0] i_gyro_rate,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [1:0]              o_channel_out,
    output logic signed [31:0]      o_angle_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    localparam int N = abkf_pkg::CHANNELS;
    localparam int W = abkf_pkg::SUM_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_P1   = 4'd1;
    localparam logic [3:0] S_P2   = 4'd2;
    localparam logic [3:0] S_P3   = 4'd3;
    localparam logic [3:0] S_P4   = 4'd4;
    localparam logic [3:0] S_P5   = 4'd5;
    localparam logic [3:0] S_GAIN = 4'd6;
    localparam logic [3:0] S_D1   = 4'd7;
    localparam logic [3:0] S_D2   = 4'd8;
    localparam logic [3:0] S_M5   = 4'd9;
    localparam logic [3:0] S_M6   = 4'd10;
    localparam logic [3:0] S_M7   = 4'd11;
    localparam logic [3:0] S_M8   = 4'd12;
    localparam logic [3:0] S_M9   = 4'd13;
    localparam logic [3:0] S_M10  = 4'd14;
    localparam logic [3:0] S_DONE = 4'd15;

    logic [abkf_pkg::CFG_W-1:0] r_q_angle, r_q_bias, r_r_noise, r_dt;

    logic signed [31:0] r_ang [N];
    logic signed [31:0] r_bia [N];
    logic signed [31:0] r_p00 [N];
    logic signed [31:0] r_cc  [N];
    logic signed [31:0] r_p11 [N];

    logic [3:0]                  r_state, n_state;
    logic [1:0]                  r_ch;
    logic [abkf_pkg::IDX_W-1:0]  r_idx;
    logic signed [31:0]          r_obs, r_rate;
    logic signed [31:0]          r_a, r_b, r_p, r_c, r_q;
    logic signed [31:0]          r_ap, r_dc, r_dd, r_pp, r_cp, r_qp, r_k1, r_k2;
    logic signed [31:0]          r_an, r_bn, r_pn, r_cn;
    logic                        r_ov;
    logic [1:0]                  r_och;
    logic signed [31:0]          r_oang;

    logic signed [abkf_pkg::MOP_W-1:0]  w_ma, w_mb;
    logic signed [abkf_pkg::MRES_W-1:0] w_mres;
    logic signed [31:0]                 w_msat;
    logic signed [32:0]                 w_e;
    logic signed [33:0]                 w_s;
    logic                               w_in_acc, w_cfg_wr, w_div_start;
    logic signed [31:0]                 w_div_num, w_quot;
    abkf_pkg::t_div_ctl                 w_div;

    assign pready      = 1'b1;
    assign w_cfg_wr    = psel && penable && pwrite;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ov;
    assign o_channel_out = r_och;
    assign o_angle_out = r_oang;

    always_comb begin
        case (paddr[3:2])
            abkf_pkg::REG_Q_ANGLE: prdata = {1'b0, r_q_angle};
            abkf_pkg::REG_Q_BIAS:  prdata = {1'b0, r_q_bias};
            abkf_pkg::REG_R_NOISE: prdata = {1'b0, r_r_noise};
            abkf_pkg::REG_DT:      prdata = {1'b0, r_dt};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_angle <= abkf_pkg::RST_Q_ANGLE;
            r_q_bias  <= abkf_pkg::RST_Q_BIAS;
            r_r_noise <= abkf_pkg::RST_R_NOISE;
            r_dt      <= abkf_pkg::RST_DT;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                abkf_pkg::REG_Q_ANGLE: r_q_angle <= pwdata[30:0];
                abkf_pkg::REG_Q_BIAS:  r_q_bias  <= pwdata[30:0];
                abkf_pkg::REG_R_NOISE: r_r_noise <= pwdata[30:0];
                abkf_pkg::REG_DT:      r_dt      <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // Shared multiplier: the operand pair follows the sequencer state.
    assign w_msat = abkf_pkg::sat32(W'(w_mres));
    assign w_e    = 33'(r_obs) - 33'(r_ap);
    assign w_s    = 34'(r_pp) + 34'(signed'({1'b0, r_r_noise}));

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_P1: begin
                w_ma = abkf_pkg::MOP_W'(33'(r_rate) - 33'(r_b));
                w_mb = abkf_pkg::MOP_W'({1'b0, r_dt});
            end
            S_P2: begin
                w_ma = abkf_pkg::MOP_W'(r_c);
                w_mb = abkf_pkg::MOP_W'({1'b0, r_dt});
            end
            S_P3: begin
                w_ma = abkf_pkg::MOP_W'(r_q);
                w_mb = abkf_pkg::MOP_W'({1'b0, r_dt});
            end
            S_P4: begin
                w_ma = abkf_pkg::MOP_W'(w_msat);
                w_mb = abkf_pkg::MOP_W'({1'b0, r_dt});
            end
            S_M5: begin
                w_ma = abkf_pkg::MOP_W'(r_k1);
                w_mb = abkf_pkg::MOP_W'(w_e);
            end
            S_M6: begin
                w_ma = abkf_pkg::MOP_W'(r_k2);
                w_mb = abkf_pkg::MOP_W'(w_e);
            end
            S_M7: begin
                w_ma = abkf_pkg::MOP_W'(r_k1);
                w_mb = abkf_pkg::MOP_W'(r_pp);
            end
            S_M8: begin
                w_ma = abkf_pkg::MOP_W'(r_k1);
                w_mb = abkf_pkg::MOP_W'(r_cp);
            end
            S_M9: begin
                w_ma = abkf_pkg::MOP_W'(r_k2);
                w_mb = abkf_pkg::MOP_W'(r_cp);
            end
            default: ;
        endcase
    end

    abkf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_res (w_mres)
    );

    // Start the first gain division from the gain state, the second once the first is done.
    assign w_div_start = ((r_state == S_GAIN) && (w_s > 34'sd0)) ||
                         ((r_state == S_D1) && !w_div.busy);
    assign w_div_num   = (r_state == S_GAIN) ? r_pp : r_cp;

    abkf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_s[31:0]),
        .o_ctl   (w_div),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_in_acc) begin
                n_state = ({30'd0, i_channel} < N) ? S_P1 : S_DONE;
            end
            S_P1:   n_state = S_P2;
            S_P2:   n_state = S_P3;
            S_P3:   n_state = S_P4;
            S_P4:   n_state = S_P5;
            S_P5:   n_state = S_GAIN;
            S_GAIN: n_state = (w_s > 34'sd0) ? S_D1 : S_M5;
            S_D1:   if (!w_div.busy) n_state = S_D2;
            S_D2:   if (!w_div.busy) n_state = S_M5;
            S_M5:   n_state = S_M6;
            S_M6:   n_state = S_M7;
            S_M7:   n_state = S_M8;
            S_M8:   n_state = S_M9;
            S_M9:   n_state = S_M10;
            S_M10:  n_state = S_DONE;
            S_DONE: if (!r_ov || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Datapath: capture each multiplier result in the state after its operands.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (w_in_acc) begin
                r_ch   <= i_channel;
                r_idx  <= abkf_pkg::IDX_W'(i_channel);
                r_obs  <= i_observed_angle;
                r_rate <= i_gyro_rate;
                r_a    <= r_ang[abkf_pkg::IDX_W'(i_channel)];
                r_b    <= r_bia[abkf_pkg::IDX_W'(i_channel)];
                r_p    <= r_p00[abkf_pkg::IDX_W'(i_channel)];
                r_c    <= r_cc[abkf_pkg::IDX_W'(i_channel)];
                r_q    <= r_p11[abkf_pkg::IDX_W'(i_channel)];
            end
            S_P2: r_ap <= abkf_pkg::sat32(W'(r_a) + W'(w_mres));
            S_P3: r_dc <= w_msat;
            S_P4: r_dd <= w_msat;
            S_P5: begin
                r_pp <= abkf_pkg::sat32(W'(r_p) - 2 * W'(r_dc) + W'(w_msat) +
                                        W'(signed'({1'b0, r_q_angle})));
                r_cp <= abkf_pkg::sat32(W'(r_c) - W'(r_dd));
                r_qp <= abkf_pkg::sat32(W'(r_q) + W'(signed'({1'b0, r_q_bias})));
            end
            S_GAIN: begin
                r_k1 <= '0;
                r_k2 <= '0;
            end
            S_D1: if (!w_div.busy) r_k1 <= w_quot;
            S_D2: if (!w_div.busy) r_k2 <= w_quot;
            S_M6:  r_an <= abkf_pkg::sat32(W'(r_ap) + W'(w_mres));
            S_M7:  r_bn <= abkf_pkg::sat32(W'(r_b) + W'(w_mres));
            S_M8:  r_pn <= abkf_pkg::sat32(W'(r_pp) - W'(w_msat));
            S_M9:  r_cn <= abkf_pkg::sat32(W'(r_cp) - W'(w_msat));
            default: ;
        endcase
    end

    // Write back the channel state at the end of the update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_ang[i] <= '0;
                r_bia[i] <= '0;
                r_p00[i] <= abkf_pkg::ONE_Q24;
                r_cc[i]  <= '0;
                r_p11[i] <= abkf_pkg::ONE_Q24;
            end
        end else if (r_state == S_M10) begin
            r_ang[r_idx] <= r_an;
            r_bia[r_idx] <= r_bn;
            r_p00[r_idx] <= r_pn;
            r_cc[r_idx]  <= r_cn;
            r_p11[r_idx] <= abkf_pkg::sat32(W'(r_qp) - W'(w_msat));
        end
    end

    // Output register: load on finish, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((r_state == S_DONE) && (!r_ov || !i_out_stall)) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && (!r_ov || !i_out_stall)) begin
            r_och  <= r_ch;
            r_oang <= ({30'd0, r_ch} < N) ? r_an : 32'sd0;
        end
    end

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("input not stalled after accepting a word");
    a_bad_channel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ({30'd0, o_channel_out} >= N)) |-> (o_angle_out == 32'sd0))
        else $error("out-of-range channel returned a nonzero angle");
    a_div_only_in_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.busy |-> ((r_state == S_D1) || (r_state == S_D2)))
        else $error("divider running outside the gain states");
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.start |-> !w_div.busy)
        else $error("divider started while busy");
`endif

endmodule
`default_nettype wire

// ===== sv/abkf_mul.sv =====
`default_nettype none
module abkf_mul (
    input  wire logic                                 i_clk,
    input  wire logic signed [abkf_pkg::MOP_W-1:0]    i_a,
    input  wire logic signed [abkf_pkg::MOP_W-1:0]    i_b,
    output logic signed [abkf_pkg::MRES_W-1:0]        o_res
);
    logic signed [2*abkf_pkg::MOP_W-1:0] w_prod;
    logic signed [abkf_pkg::MRES_W-1:0]  r_res;

    assign w_prod = i_a * i_b;

    // floor of product over 2^24
    always_ff @(posedge i_clk) begin
        r_res <= w_prod[abkf_pkg::MRES_W+23:24];
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

// ===== sv/abkf_div.sv =====
`default_nettype none
module abkf_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic signed [31:0]             i_num,
    input  wire logic [abkf_pkg::DEN_W-1:0]     i_den,
    output abkf_pkg::t_div_ctl                  o_ctl,
    output logic signed [31:0]                  o_quot
);
    localparam int CNT_W = $clog2(abkf_pkg::NUM_W + 1);

    logic                            r_busy;
    logic [CNT_W-1:0]                r_cnt;
    logic [abkf_pkg::NUM_W-1:0]      r_q;
    logic [abkf_pkg::DEN_W:0]        r_rem;
    logic [abkf_pkg::DEN_W-1:0]      r_den;
    logic                            r_neg;
    logic [abkf_pkg::DEN_W:0]        w_trial;
    logic [abkf_pkg::DEN_W+1:0]      w_diff;
    logic [32:0]                     w_mag;

    assign w_mag   = i_num[31] ? (33'd0 - {i_num[31], i_num}) : {1'b0, i_num};
    assign w_trial = {r_rem[abkf_pkg::DEN_W-1:0], r_q[abkf_pkg::NUM_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(abkf_pkg::NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) r_busy <= 1'b0;
        end
    end

    // one quotient bit a cycle, restoring
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= {w_mag[abkf_pkg::NUM_W-25:0], 24'd0};
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[31];
        end else if (r_busy) begin
            if (!w_diff[abkf_pkg::DEN_W+1]) begin
                r_rem <= w_diff[abkf_pkg::DEN_W:0];
                r_q   <= {r_q[abkf_pkg::NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_q   <= {r_q[abkf_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (r_neg) begin
            if (r_q > abkf_pkg::NUM_W'(64'h80000000)) o_quot = 32'sh80000000;
            else o_quot = 32'(abkf_pkg::NUM_W'(0) - r_q);
        end else begin
            if (r_q > abkf_pkg::NUM_W'(64'h7fffffff)) o_quot = 32'sh7fffffff;
            else o_quot = r_q[31:0];
        end
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
endmodule
`default_nettype wire

// ===== tb/tb_angle_bias_kalman_filter_core.sv =====
`timescale 1ns / 1ps
module tb_angle_bias_kalman_filter_core;

    localparam int MAX_CYCLES = 2_000_000;
    localparam int DIR_ROWS   = 14;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [1:0] i_channel = '0;
    logic signed [31:0] i_observed_angle = '0;
    logic signed [31:0] i_gyro_rate = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [1:0] o_channel_out;
    logic signed [31:0] o_angle_out;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    angle_bias_kalman_filter_core u_dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_channel, .i_observed_angle,
        .i_gyro_rate, .o_out_valid, .i_out_stall, .o_channel_out, .o_angle_out,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [1:0]         ch;
        logic signed [31:0] angle;
    } t_estimate;

    // directed row: input word plus an optional hand-read expectation
    typedef struct {
        logic [1:0]         ch;
        logic signed [31:0] obs;
        logic signed [31:0] rate;
        bit                 known;
        logic signed [31:0] angle;
    } t_dir_row;

    // predictor copy of registers and channel state
    longint q_ang_m, q_bias_m, r_m, dt_m;
    longint ang_m[abkf_pkg::CHANNELS], bias_m[abkf_pkg::CHANNELS],
            p00_m[abkf_pkg::CHANNELS], pc_m[abkf_pkg::CHANNELS],
            p11_m[abkf_pkg::CHANNELS];

    t_estimate  pending_q[$];
    int         errors = 0;
    int         cycles = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint shr24(longint v);
        return v >>> 24; // arithmetic shift floors
    endfunction

    function automatic longint qmul(longint a, longint b);
        return clamp32(shr24(a * b));
    endfunction

    function automatic void cfg_model(int idx, logic [31:0] v);
        longint m;
        m = longint'(v & 32'h7fff_ffff);
        case (idx)
            abkf_pkg::REG_Q_ANGLE: q_ang_m = m;
            abkf_pkg::REG_Q_BIAS:  q_bias_m = m;
            abkf_pkg::REG_R_NOISE: r_m = m;
            abkf_pkg::REG_DT:      dt_m = m;
            default: ;
        endcase
    endfunction

    function automatic void reset_model();
        q_ang_m = abkf_pkg::RST_Q_ANGLE; q_bias_m = abkf_pkg::RST_Q_BIAS;
        r_m = abkf_pkg::RST_R_NOISE; dt_m = abkf_pkg::RST_DT;
        for (int i = 0; i < abkf_pkg::CHANNELS; i++) begin
            ang_m[i] = 0; bias_m[i] = 0; p00_m[i] = abkf_pkg::ONE_Q24; pc_m[i] = 0;
            p11_m[i] = abkf_pkg::ONE_Q24;
        end
    endfunction

    // one filter step: returns the new angle estimate for the channel
    function automatic t_estimate fuse_angle(logic [1:0] ch, logic signed [31:0] obs,
                                             logic signed [31:0] rate);
        t_estimate r;
        int n;
        longint ap, dc, dd, p00, c, p11, s, k1, k2, e;
        r.ch = ch;
        r.angle = '0;
        if (ch >= abkf_pkg::CHANNELS) return r;
        n = ch;
        ap  = clamp32(ang_m[n] + shr24((longint'(rate) - bias_m[n]) * dt_m));
        dc  = qmul(pc_m[n], dt_m);
        dd  = qmul(p11_m[n], dt_m);
        p00 = clamp32(p00_m[n] - 2 * dc + qmul(dd, dt_m) + q_ang_m);
        c   = clamp32(pc_m[n] - dd);
        p11 = clamp32(p11_m[n] + q_bias_m);
        s   = p00 + r_m;
        k1 = 0; k2 = 0;
        if (s > 0) begin
            k1 = clamp32((p00 * abkf_pkg::ONE_Q24) / s);
            k2 = clamp32((c * abkf_pkg::ONE_Q24) / s);
        end
        e = longint'(obs) - ap;
        ang_m[n]  = clamp32(ap + shr24(k1 * e));
        bias_m[n] = clamp32(bias_m[n] + shr24(k2 * e));
        p00_m[n]  = clamp32(p00 - qmul(k1, p00));
        pc_m[n]   = clamp32(c - qmul(k1, c));
        p11_m[n]  = clamp32(p11 - qmul(k2, c));
        r.angle = 32'(ang_m[n]);
        return r;
    endfunction

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("angle_bias_kalman_filter_core: mismatch");
            $finish;
        end
    end

    // receiver: random stall, check each accepted word against the oldest estimate
    always @(posedge i_clk) begin
        t_estimate want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word ch=%0d angle=%0d",
                                           o_channel_out, o_angle_out);
            end else begin
                want = pending_q.pop_front();
                if (want.ch !== o_channel_out || want.angle !== o_angle_out) begin
                    errors++;
                    if (errors <= 10)
                        $display("word mismatch: exp ch=%0d angle=%0d got ch=%0d angle=%0d",
                                 want.ch, want.angle, o_channel_out, o_angle_out);
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic cfg_write(int idx, logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 4'(idx * 4); pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        cfg_model(idx, v);
    endtask

    // send one word; add its estimate (or the hand-typed one) to the queue
    task automatic send_word(logic [1:0] ch, logic signed [31:0] obs,
                             logic signed [31:0] rate, bit known,
                             logic signed [31:0] angle);
        t_estimate est;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1; i_channel <= ch; i_observed_angle <= obs; i_gyro_rate <= rate;
        do @(posedge i_clk); while (o_in_stall);
        est = fuse_angle(ch, obs, rate);
        if (known) est.angle = angle;
        pending_q.push_back(est);
    endtask

    // hold until all estimates are back, then let the core settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic random_words(int count);
        logic [1:0] ch;
        logic signed [31:0] obs, rate;
        for (int i = 0; i < count; i++) begin
            ch = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
            case ($urandom_range(3))
                0: begin obs = $urandom; rate = $urandom; end
                1: begin
                    obs = $signed(32'($urandom_range(0, 2 * 5898240))) - 32'sd5898240;
                    rate = $signed(32'($urandom_range(0, 2 * 655360))) - 32'sd655360;
                end
                2: begin
                    obs = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
                    rate = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
                end
                default: begin
                    obs = $signed(32'($urandom_range(0, 131072))) - 32'sd65536;
                    rate = $urandom;
                end
            endcase
            send_word(ch, obs, rate, 1'b0, '0);
        end
    endtask

    t_dir_row dir_rows[DIR_ROWS];

    initial begin
        // extremes, every channel, the out-of-range channel
        dir_rows[0]  = '{2'd3, 32'sh7fffffff, 32'sh7fffffff, 1'b1, 32'sd0};
        dir_rows[1]  = '{2'd0, 32'sd0, 32'sd0, 1'b1, 32'sd0};
        dir_rows[2]  = '{2'd1, 32'sd0, 32'sd0, 1'b1, 32'sd0};
        dir_rows[3]  = '{2'd2, 32'sd0, 32'sd0, 1'b1, 32'sd0};
        dir_rows[4]  = '{2'd0, 32'sh7fffffff, 32'sh7fffffff, 1'b0, 32'sd0};
        dir_rows[5]  = '{2'd0, 32'sh80000000, 32'sh80000000, 1'b0, 32'sd0};
        dir_rows[6]  = '{2'd1, 32'sh80000000, 32'sh7fffffff, 1'b0, 32'sd0};
        dir_rows[7]  = '{2'd2, 32'sh7fffffff, 32'sh80000000, 1'b0, 32'sd0};
        dir_rows[8]  = '{2'd3, 32'sh80000000, 32'sh80000000, 1'b1, 32'sd0};
        dir_rows[9]  = '{2'd1, 32'sd655360, 32'sd65536, 1'b0, 32'sd0};
        dir_rows[10] = '{2'd2, -32'sd655360, -32'sd65536, 1'b0, 32'sd0};
        dir_rows[11] = '{2'd0, 32'sh55555555, 32'shaaaaaaaa, 1'b0, 32'sd0};
        dir_rows[12] = '{2'd1, 32'shaaaaaaaa, 32'sh55555555, 1'b0, 32'sd0};
        dir_rows[13] = '{2'd3, 32'sd1, -32'sd1, 1'b1, 32'sd0};

        reset_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].ch, dir_rows[i].obs, dir_rows[i].rate,
                      dir_rows[i].known, dir_rows[i].angle);
        drain();

        // phase A: reset registers, no idling
        random_words(110);
        drain();

        // phase B: extremes of the registers, sender idle
        send_idle_pct = 68;
        cfg_write(abkf_pkg::REG_Q_ANGLE, 32'h7fff_ffff);
        cfg_write(abkf_pkg::REG_Q_BIAS, 32'h7fff_ffff);
        cfg_write(abkf_pkg::REG_R_NOISE, 32'h0000_0001);
        cfg_write(abkf_pkg::REG_DT, 32'h7fff_ffff);
        random_words(80);
        drain();

        // phase C: no process noise, maximum measurement noise, minimum dt, receiver stalling
        send_idle_pct = 0; recv_stall_pct = 68;
        cfg_write(abkf_pkg::REG_Q_ANGLE, 32'h0);
        cfg_write(abkf_pkg::REG_Q_BIAS, 32'h0);
        cfg_write(abkf_pkg::REG_R_NOISE, 32'h7fff_ffff);
        cfg_write(abkf_pkg::REG_DT, 32'h0000_0001);
        random_words(110);
        drain();

        // phase D: random registers (top bit of noise and dt set to check masking), both idling
        send_idle_pct = 14; recv_stall_pct = 14;
        cfg_write(abkf_pkg::REG_Q_ANGLE, $urandom);
        cfg_write(abkf_pkg::REG_Q_BIAS, $urandom);
        cfg_write(abkf_pkg::REG_R_NOISE, 32'h8000_0000 | 32'($urandom_range(1, 33554432)));
        cfg_write(abkf_pkg::REG_DT, 32'h8000_0000 | 32'($urandom_range(1, 1677722)));
        random_words(110);
        drain();

        // phase E: typical IMU settings, no idling
        send_idle_pct = 0; recv_stall_pct = 0;
        cfg_write(abkf_pkg::REG_Q_ANGLE, 32'd16777);
        cfg_write(abkf_pkg::REG_Q_BIAS, 32'd50332);
        cfg_write(abkf_pkg::REG_R_NOISE, 32'd8388608);
        cfg_write(abkf_pkg::REG_DT, 32'd83886);
        random_words(130);
        drain();

        if (errors == 0)
            $display("angle_bias_kalman_filter_core: match");
        else
            $display("angle_bias_kalman_filter_core: mismatch");
        $finish;
    end
endmodule
